// File: rtl/lruwb_pkg.sv
// Shared types and codes for the fully associative write-back cache controller.
package lruwb_pkg;

  typedef enum logic [2:0] {
    OP_GET       = 3'd0,
    OP_MARK      = 3'd1,
    OP_FLUSH     = 3'd2,
    OP_INV       = 3'd3,
    OP_FLUSH_ALL = 3'd4,
    OP_CLEAR     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ACT_HIT  = 2'd0,
    ACT_WB   = 2'd1,
    ACT_FILL = 2'd2,
    ACT_DONE = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE,
    ST_EMIT,
    ST_WALK_RD,
    ST_WALK_CHK
  } state_t;

  // Running flags of the tag scan.
  typedef struct packed {
    logic hit;
    logic free;
  } scan_flags_t;

endpackage

// File: rtl/lruwb_if.sv
// Valid/ready channel interfaces for operation items and result items.
interface lruwb_in_if #(
  parameter int ID_WIDTH = 16
);
  logic                valid;
  logic                ready;
  logic [2:0]          operation;
  logic [ID_WIDTH-1:0] item_id;

  modport source (output valid, output operation, output item_id, input ready);
  modport sink   (input valid, input operation, input item_id, output ready);
endinterface

interface lruwb_out_if #(
  parameter int ENTRIES  = 16,
  parameter int ID_WIDTH = 16
);
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);

  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [IDX_W-1:0]    slot;
  logic [ID_WIDTH-1:0] target_id;
  logic                found;
  logic [31:0]         hit_total;
  logic [31:0]         miss_total;
  logic [31:0]         eviction_total;
  logic [CNT_W-1:0]    occupancy;
  logic                last;

  modport source (output valid, output action, output slot, output target_id, output found,
                  output hit_total, output miss_total, output eviction_total,
                  output occupancy, output last, input ready);
  modport sink   (input valid, input action, input slot, input target_id, input found,
                  input hit_total, input miss_total, input eviction_total,
                  input occupancy, input last, output ready);
endinterface

// File: rtl/lru_writeback_cache_controller_core.sv
// Top level of the fully associative LRU write-back cache tag controller.
// A get, mark dirty, flush one or invalidate scans every entry once through the tag/age
// memory read port before its first result; flush all and clear read every entry in turn.
// A new item is taken only in the idle state, after the last result of the previous one
// has been loaded into the output register; output stalls hold the sequencer. Reset clears
// valid and dirty bits, counters and control state at once; the memories are not reset.
module lru_writeback_cache_controller_core #(
  parameter int ENTRIES  = 16,
  parameter int AGE_MAX  = 255,
  parameter int ID_WIDTH = 16
) (
  input logic              clk,
  input logic              rst_n,
  lruwb_in_if.sink         in_ch,
  lruwb_out_if.source      out_ch
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int AGE_W = $clog2(AGE_MAX + 1);

  // Sequencer state and the operation being worked on.
  lruwb_pkg::state_t state_r, state_nxt;
  logic [2:0]          op_r, op_nxt;
  logic [ID_WIDTH-1:0] id_r, id_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pipe_vld_r, pipe_vld_nxt;
  logic [IDX_W-1:0]    pipe_idx_r, pipe_idx_nxt;

  // Entry status bits live in flip-flops so that reset clears them at once.
  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [ENTRIES-1:0]  dirty_r, dirty_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [31:0]         hit_cnt_r, hit_cnt_nxt;
  logic [31:0]         miss_cnt_r, miss_cnt_nxt;
  logic [31:0]         evict_cnt_r, evict_cnt_nxt;

  // Outcome of the scan, held for the result sequence.
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic                found_r, found_nxt;
  logic                wb_pend_r, wb_pend_nxt;
  logic [ID_WIDTH-1:0] wb_tag_r, wb_tag_nxt;

  // Output register.
  logic                out_valid_r;
  logic [1:0]          out_action_r;
  logic [IDX_W-1:0]    out_slot_r;
  logic [ID_WIDTH-1:0] out_target_r;
  logic                out_found_r;
  logic [31:0]         out_hit_r;
  logic [31:0]         out_miss_r;
  logic [31:0]         out_evict_r;
  logic [CNT_W-1:0]    out_used_r;
  logic                out_last_r;

  // Result load request from the sequencer.
  logic                ld;
  lruwb_pkg::act_t     ld_action;
  logic [IDX_W-1:0]    ld_slot;
  logic [ID_WIDTH-1:0] ld_target;
  logic                ld_found;
  logic                ld_last;
  logic [CNT_W-1:0]    ld_used;
  logic                can_load;

  // Memory and scan unit connections.
  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  logic [ID_WIDTH-1:0] rd_tag;
  logic [AGE_W-1:0]    rd_age;
  logic                tag_we;
  logic [IDX_W-1:0]    tag_waddr;
  logic                age_we;
  logic [IDX_W-1:0]    age_waddr;
  logic [AGE_W-1:0]    age_wdata;
  logic                scan_start;
  logic [AGE_W-1:0]    age_inc;
  lruwb_pkg::scan_flags_t flags;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    free_idx;
  logic [IDX_W-1:0]    vic_idx;
  logic [ID_WIDTH-1:0] vic_tag;
  logic [IDX_W-1:0]    fill_idx;
  logic [IDX_W-1:0]    walk_idx;
  logic                in_ready_c;

  lruwb_store #(
    .ENTRIES  (ENTRIES),
    .ID_WIDTH (ID_WIDTH),
    .AGE_W    (AGE_W)
  ) u_store (
    .clk       (clk),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_tag    (rd_tag),
    .rd_age    (rd_age),
    .tag_we    (tag_we),
    .tag_waddr (tag_waddr),
    .tag_wdata (id_r),
    .age_we    (age_we),
    .age_waddr (age_waddr),
    .age_wdata (age_wdata)
  );

  // The scan unit sees each entry in the cycle after its memory read is issued.
  lruwb_scan #(
    .ENTRIES  (ENTRIES),
    .ID_WIDTH (ID_WIDTH),
    .AGE_MAX  (AGE_MAX),
    .AGE_W    (AGE_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (scan_start),
    .proc      (pipe_vld_r),
    .idx       (pipe_idx_r),
    .id        (id_r),
    .tag       (rd_tag),
    .age       (rd_age),
    .ent_valid (valid_r[pipe_idx_r]),
    .age_inc   (age_inc),
    .flags     (flags),
    .hit_idx   (hit_idx),
    .free_idx  (free_idx),
    .vic_idx   (vic_idx),
    .vic_tag   (vic_tag)
  );

  assign can_load = !out_valid_r || out_ch.ready;
  assign fill_idx = flags.free ? free_idx : vic_idx;
  assign walk_idx = cnt_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lruwb_pkg::ST_IDLE;
      cnt_r       <= '0;
      pipe_vld_r  <= 1'b0;
      valid_r     <= '0;
      dirty_r     <= '0;
      used_r      <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      evict_cnt_r <= '0;
      wb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      valid_r     <= valid_nxt;
      dirty_r     <= dirty_nxt;
      used_r      <= used_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      evict_cnt_r <= evict_cnt_nxt;
      wb_pend_r   <= wb_pend_nxt;
      if (ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    pipe_idx_r <= pipe_idx_nxt;
    slot_r     <= slot_nxt;
    found_r    <= found_nxt;
    wb_tag_r   <= wb_tag_nxt;
    if (ld) begin
      out_action_r <= ld_action;
      out_slot_r   <= ld_slot;
      out_target_r <= ld_target;
      out_found_r  <= ld_found;
      out_hit_r    <= hit_cnt_r;
      out_miss_r   <= miss_cnt_r;
      out_evict_r  <= evict_cnt_r;
      out_used_r   <= ld_used;
      out_last_r   <= ld_last;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    cnt_nxt       = cnt_r;
    pipe_vld_nxt  = 1'b0;
    pipe_idx_nxt  = pipe_idx_r;
    valid_nxt     = valid_r;
    dirty_nxt     = dirty_r;
    used_nxt      = used_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    evict_cnt_nxt = evict_cnt_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    wb_pend_nxt   = wb_pend_r;
    wb_tag_nxt    = wb_tag_r;
    scan_start    = 1'b0;
    in_ready_c    = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = walk_idx;
    tag_we        = 1'b0;
    tag_waddr     = fill_idx;
    age_we        = 1'b0;
    age_waddr     = pipe_idx_r;
    age_wdata     = age_inc;
    ld            = 1'b0;
    ld_action     = lruwb_pkg::ACT_DONE;
    ld_slot       = '0;
    ld_target     = '0;
    ld_found      = 1'b0;
    ld_last       = 1'b1;
    ld_used       = used_r;

    unique case (state_r)
      lruwb_pkg::ST_IDLE: begin
        in_ready_c = 1'b1;
        if (in_ch.valid) begin
          op_nxt      = in_ch.operation;
          id_nxt      = in_ch.item_id;
          cnt_nxt     = '0;
          scan_start  = 1'b1;
          wb_pend_nxt = 1'b0;
          found_nxt   = 1'b0;
          slot_nxt    = '0;
          case (in_ch.operation) inside
            lruwb_pkg::OP_GET, lruwb_pkg::OP_MARK, lruwb_pkg::OP_FLUSH, lruwb_pkg::OP_INV: begin
              state_nxt = lruwb_pkg::ST_SCAN;
            end
            lruwb_pkg::OP_FLUSH_ALL, lruwb_pkg::OP_CLEAR: begin
              state_nxt = lruwb_pkg::ST_WALK_RD;
            end
            default: begin
              state_nxt = lruwb_pkg::ST_EMIT;
            end
          endcase
        end
      end

      // One memory read per cycle; a get also ages every entry as it passes the unit.
      lruwb_pkg::ST_SCAN: begin
        if (cnt_r != CNT_W'(ENTRIES)) begin
          rd_en        = 1'b1;
          cnt_nxt      = cnt_r + CNT_W'(1);
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = walk_idx;
        end else if (pipe_vld_r) begin
          state_nxt = lruwb_pkg::ST_RESOLVE;
        end
        age_we = pipe_vld_r && (op_r == lruwb_pkg::OP_GET);
      end

      // Scanned ops change state here, save scan ageing and an invalidate's entry drop.
      lruwb_pkg::ST_RESOLVE: begin
        state_nxt = lruwb_pkg::ST_EMIT;
        found_nxt = flags.hit;
        slot_nxt  = flags.hit ? hit_idx : '0;
        case (op_r)
          lruwb_pkg::OP_GET: begin
            age_wdata = '0;
            if (flags.hit) begin
              hit_cnt_nxt = hit_cnt_r + 32'd1;
              age_we      = 1'b1;
              age_waddr   = hit_idx;
            end else begin
              miss_cnt_nxt = miss_cnt_r + 32'd1;
              if (flags.free) begin
                used_nxt = used_r + CNT_W'(1);
              end else begin
                // Cache full: the oldest entry is replaced in place.
                evict_cnt_nxt = evict_cnt_r + 32'd1;
                wb_pend_nxt   = dirty_r[vic_idx];
                wb_tag_nxt    = vic_tag;
              end
              valid_nxt[fill_idx] = 1'b1;
              dirty_nxt[fill_idx] = 1'b0;
              tag_we              = 1'b1;
              age_we              = 1'b1;
              age_waddr           = fill_idx;
              slot_nxt            = fill_idx;
            end
          end
          lruwb_pkg::OP_MARK: begin
            if (flags.hit) begin
              dirty_nxt[hit_idx] = 1'b1;
            end
          end
          default: begin
            // Flush one and invalidate both write a dirty hit back first.
            if (flags.hit && dirty_r[hit_idx]) begin
              dirty_nxt[hit_idx] = 1'b0;
              wb_pend_nxt        = 1'b1;
              wb_tag_nxt         = id_r;
            end
          end
        endcase
      end

      lruwb_pkg::ST_EMIT: begin
        if (can_load) begin
          ld = 1'b1;
          if (wb_pend_r) begin
            wb_pend_nxt = 1'b0;
            ld_action   = lruwb_pkg::ACT_WB;
            ld_slot     = slot_r;
            ld_target   = wb_tag_r;
            ld_last     = 1'b0;
            if (op_r == lruwb_pkg::OP_GET) begin
              // The victim counts as dropped until its fill result.
              ld_used  = used_r - CNT_W'(1);
              ld_found = 1'b0;
            end else begin
              ld_found = 1'b1;
            end
          end else begin
            state_nxt = lruwb_pkg::ST_IDLE;
            case (op_r) inside
              lruwb_pkg::OP_GET: begin
                ld_action = found_r ? lruwb_pkg::ACT_HIT : lruwb_pkg::ACT_FILL;
                ld_slot   = slot_r;
                ld_target = id_r;
                ld_found  = found_r;
              end
              lruwb_pkg::OP_MARK, lruwb_pkg::OP_FLUSH: begin
                ld_slot   = slot_r;
                ld_target = id_r;
                ld_found  = found_r;
              end
              lruwb_pkg::OP_INV: begin
                ld_slot   = slot_r;
                ld_target = id_r;
                ld_found  = found_r;
                if (found_r) begin
                  valid_nxt[slot_r] = 1'b0;
                  dirty_nxt[slot_r] = 1'b0;
                  used_nxt          = used_r - CNT_W'(1);
                  ld_used           = used_r - CNT_W'(1);
                end
              end
              lruwb_pkg::OP_CLEAR: begin
                valid_nxt = '0;
                dirty_nxt = '0;
                used_nxt  = '0;
                ld_used   = '0;
              end
              default: begin
                ld_slot = '0;
              end
            endcase
          end
        end
      end

      lruwb_pkg::ST_WALK_RD: begin
        rd_en     = 1'b1;
        state_nxt = lruwb_pkg::ST_WALK_CHK;
      end

      // The tag read is held until a dirty entry's writeback can be loaded.
      lruwb_pkg::ST_WALK_CHK: begin
        if (!(valid_r[walk_idx] && dirty_r[walk_idx]) || can_load) begin
          if (valid_r[walk_idx] && dirty_r[walk_idx]) begin
            ld                  = 1'b1;
            ld_action           = lruwb_pkg::ACT_WB;
            ld_slot             = walk_idx;
            ld_target           = rd_tag;
            ld_found            = 1'b1;
            ld_last             = 1'b0;
            dirty_nxt[walk_idx] = 1'b0;
          end
          if (cnt_r == CNT_W'(ENTRIES - 1)) begin
            state_nxt = lruwb_pkg::ST_EMIT;
          end else begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            state_nxt = lruwb_pkg::ST_WALK_RD;
          end
        end
      end

      default: begin
        state_nxt = lruwb_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_ch.ready           = in_ready_c;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.action         = out_action_r;
  assign out_ch.slot           = out_slot_r;
  assign out_ch.target_id      = out_target_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.hit_total      = out_hit_r;
  assign out_ch.miss_total     = out_miss_r;
  assign out_ch.eviction_total = out_evict_r;
  assign out_ch.occupancy      = out_used_r;
  assign out_ch.last           = out_last_r;

endmodule

// File: rtl/lruwb_store.sv
// Tag and age memories, one write port each and a shared read address with registered read data.
module lruwb_store #(
  parameter int ENTRIES  = 16,
  parameter int ID_WIDTH = 16,
  parameter int AGE_W    = 8
) (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [ID_WIDTH-1:0]        rd_tag,
  output logic [AGE_W-1:0]           rd_age,
  input  logic                       tag_we,
  input  logic [$clog2(ENTRIES)-1:0] tag_waddr,
  input  logic [ID_WIDTH-1:0]        tag_wdata,
  input  logic                       age_we,
  input  logic [$clog2(ENTRIES)-1:0] age_waddr,
  input  logic [AGE_W-1:0]           age_wdata
);

  logic [ID_WIDTH-1:0] tag_mem [ENTRIES];
  logic [AGE_W-1:0]    age_mem [ENTRIES];
  logic [ID_WIDTH-1:0] rd_tag_r;
  logic [AGE_W-1:0]    rd_age_r;

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (rd_en) begin
      rd_tag_r <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    if (rd_en) begin
      rd_age_r <= age_mem[rd_addr];
    end
  end

  assign rd_tag = rd_tag_r;
  assign rd_age = rd_age_r;

endmodule

// File: rtl/lruwb_scan.sv
// Shared compare unit: tag match, free-slot search, oldest-entry search and age increment.
module lruwb_scan #(
  parameter int ENTRIES  = 16,
  parameter int ID_WIDTH = 16,
  parameter int AGE_MAX  = 255,
  parameter int AGE_W    = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       proc,
  input  logic [$clog2(ENTRIES)-1:0] idx,
  input  logic [ID_WIDTH-1:0]        id,
  input  logic [ID_WIDTH-1:0]        tag,
  input  logic [AGE_W-1:0]           age,
  input  logic                       ent_valid,
  output logic [AGE_W-1:0]           age_inc,
  output lruwb_pkg::scan_flags_t     flags,
  output logic [$clog2(ENTRIES)-1:0] hit_idx,
  output logic [$clog2(ENTRIES)-1:0] free_idx,
  output logic [$clog2(ENTRIES)-1:0] vic_idx,
  output logic [ID_WIDTH-1:0]        vic_tag
);

  localparam int IDX_W = $clog2(ENTRIES);

  lruwb_pkg::scan_flags_t flags_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic [IDX_W-1:0]       free_idx_r;
  logic [IDX_W-1:0]       vic_idx_r;
  logic [AGE_W-1:0]       vic_age_r;
  logic [ID_WIDTH-1:0]    vic_tag_r;

  // Ages saturate at AGE_MAX.
  assign age_inc = (age < AGE_W'(AGE_MAX)) ? age + AGE_W'(1) : age;

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      flags_r <= '0;
    end else if (proc) begin
      if (ent_valid && (tag == id) && !flags_r.hit) begin
        flags_r.hit <= 1'b1;
      end
      if (!ent_valid && !flags_r.free) begin
        flags_r.free <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      if (ent_valid && (tag == id) && !flags_r.hit) begin
        hit_idx_r <= idx;
      end
      if (!ent_valid && !flags_r.free) begin
        free_idx_r <= idx;
      end
      // Strictly greater keeps the lowest index among equal ages.
      if ((idx == '0) || (age > vic_age_r)) begin
        vic_idx_r <= idx;
        vic_age_r <= age;
        vic_tag_r <= tag;
      end
    end
  end

  assign flags    = flags_r;
  assign hit_idx  = hit_idx_r;
  assign free_idx = free_idx_r;
  assign vic_idx  = vic_idx_r;
  assign vic_tag  = vic_tag_r;

endmodule

// File: dv/tb_lru_writeback_cache_controller_core.sv
// Self-checking testbench for the LRU write-back cache tag controller.
`timescale 1ns / 1ps

module tb_lru_writeback_cache_controller_core;

  localparam int ENTRIES  = 16;
  localparam int AGE_MAX  = 255;
  localparam int ID_WIDTH = 16;

  // Operation codes that the block does not define. It must answer them with a
  // single done item and leave its state alone.
  localparam logic [2:0] OP_UNDEF_LO = 3'd6;
  localparam logic [2:0] OP_UNDEF_HI = 3'd7;

  // The tag value that an invalidated entry carries.
  localparam logic [ID_WIDTH-1:0] ID_ALL_ONES = 16'hFFFF;

  typedef struct {
    logic [2:0]          op;
    logic [ID_WIDTH-1:0] id;
    bit                  drain_first;
  } cache_op_t;

  typedef struct {
    lruwb_pkg::act_t     action;
    logic [3:0]          slot;
    logic [ID_WIDTH-1:0] target_id;
    logic                found;
    logic [31:0]         hit_total;
    logic [31:0]         miss_total;
    logic [31:0]         eviction_total;
    logic [4:0]          occupancy;
    logic                last;
  } cache_resp_t;

  logic clk = 1'b0;
  logic rst_n;

  lruwb_in_if  #(.ID_WIDTH(ID_WIDTH))                    in_ch ();
  lruwb_out_if #(.ENTRIES(ENTRIES), .ID_WIDTH(ID_WIDTH)) out_ch ();

  lru_writeback_cache_controller_core #(
    .ENTRIES (ENTRIES),
    .AGE_MAX (AGE_MAX),
    .ID_WIDTH(ID_WIDTH)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // The testbench's own picture of the tag store. Ages are kept for every entry,
  // valid or not, because every get ages all of them.
  logic [ID_WIDTH-1:0] line_tag   [ENTRIES];
  bit                  line_valid [ENTRIES];
  bit                  line_dirty [ENTRIES];
  int unsigned         line_age   [ENTRIES];
  logic [31:0]         hit_count;
  logic [31:0]         miss_count;
  logic [31:0]         evict_count;

  cache_op_t   op_queue[$];
  cache_resp_t awaited_responses[$];
  int          mismatch_count = 0;

  int send_gap  = 0;
  int recv_wait = 0;
  bit sender_calm   = 1'b0;
  bit receiver_calm = 1'b0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int find_slot(logic [ID_WIDTH-1:0] id);
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_tag[i] == id) return i;
    end
    return -1;
  endfunction

  // Records one response item with the counters and occupancy as they stand now.
  task automatic expect_resp(lruwb_pkg::act_t act, int slot, logic [ID_WIDTH-1:0] target,
                             bit found, bit last);
    cache_resp_t r;
    int used;
    used = 0;
    for (int i = 0; i < ENTRIES; i++) used += line_valid[i];
    r.action         = act;
    r.slot           = slot[3:0];
    r.target_id      = target;
    r.found          = found;
    r.hit_total      = hit_count;
    r.miss_total     = miss_count;
    r.eviction_total = evict_count;
    r.occupancy      = used[4:0];
    r.last           = last;
    awaited_responses.push_back(r);
  endtask

  // Ages saturate at AGE_MAX; the entry that was just used becomes the youngest.
  task automatic age_entries(int idx);
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_age[i] < AGE_MAX) line_age[i]++;
    end
    line_age[idx] = 0;
  endtask

  task automatic drop_entry(int idx);
    line_valid[idx] = 1'b0;
    line_dirty[idx] = 1'b0;
    line_tag[idx]   = ID_ALL_ONES;
  endtask

  task automatic write_back_dirty();
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_dirty[i]) begin
        line_dirty[i] = 1'b0;
        expect_resp(lruwb_pkg::ACT_WB, i, line_tag[i], 1'b1, 1'b0);
      end
    end
  endtask

  task automatic predict_cache_op(logic [2:0] op, logic [ID_WIDTH-1:0] id);
    int idx;
    int victim;
    logic [ID_WIDTH-1:0] old_tag;
    idx = find_slot(id);
    case (op)
      lruwb_pkg::OP_GET: begin
        if (idx >= 0) begin
          hit_count++;
          age_entries(idx);
          expect_resp(lruwb_pkg::ACT_HIT, idx, id, 1'b1, 1'b1);
        end else begin
          miss_count++;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!line_valid[i] && idx < 0) idx = i;
          end
          if (idx < 0) begin
            // Full: the oldest entry goes, the lowest index winning a tie.
            victim = 0;
            for (int i = 1; i < ENTRIES; i++) begin
              if (line_age[i] > line_age[victim]) victim = i;
            end
            evict_count++;
            old_tag = line_tag[victim];
            if (line_dirty[victim]) begin
              drop_entry(victim);
              expect_resp(lruwb_pkg::ACT_WB, victim, old_tag, 1'b0, 1'b0);
            end else begin
              drop_entry(victim);
            end
            idx = victim;
          end
          line_valid[idx] = 1'b1;
          line_dirty[idx] = 1'b0;
          line_tag[idx]   = id;
          age_entries(idx);
          expect_resp(lruwb_pkg::ACT_FILL, idx, id, 1'b0, 1'b1);
        end
      end
      lruwb_pkg::OP_MARK: begin
        if (idx >= 0) line_dirty[idx] = 1'b1;
        expect_resp(lruwb_pkg::ACT_DONE, (idx >= 0) ? idx : 0, id, idx >= 0, 1'b1);
      end
      lruwb_pkg::OP_FLUSH, lruwb_pkg::OP_INV: begin
        if (idx >= 0) begin
          if (line_dirty[idx]) begin
            line_dirty[idx] = 1'b0;
            expect_resp(lruwb_pkg::ACT_WB, idx, line_tag[idx], 1'b1, 1'b0);
          end
          if (op == lruwb_pkg::OP_INV) drop_entry(idx);
        end
        expect_resp(lruwb_pkg::ACT_DONE, (idx >= 0) ? idx : 0, id, idx >= 0, 1'b1);
      end
      lruwb_pkg::OP_FLUSH_ALL: begin
        write_back_dirty();
        expect_resp(lruwb_pkg::ACT_DONE, 0, '0, 1'b0, 1'b1);
      end
      lruwb_pkg::OP_CLEAR: begin
        // Counters and ages survive a clear.
        write_back_dirty();
        for (int i = 0; i < ENTRIES; i++) drop_entry(i);
        expect_resp(lruwb_pkg::ACT_DONE, 0, '0, 1'b0, 1'b1);
      end
      default: begin
        expect_resp(lruwb_pkg::ACT_DONE, 0, '0, 1'b0, 1'b1);
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Operation driver
  // ---------------------------------------------------------------------------

  // A new item may be presented when the channel is empty or the current item
  // is being taken at this edge. An item marked drain_first is held back until
  // every response awaited so far has arrived.
  always @(posedge clk) begin : op_driver
    cache_op_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_cache_op(in_ch.operation, in_ch.item_id);
        if ($urandom_range(0, 24) == 0) sender_calm = !sender_calm;
        send_gap = sender_calm ? 0 : $urandom_range(0, 11);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (op_queue.size() == 0 ||
                     (op_queue[0].drain_first && awaited_responses.size() != 0)) begin
          in_ch.valid <= 1'b0;
        end else begin
          nxt = op_queue.pop_front();
          in_ch.operation <= nxt.op;
          in_ch.item_id   <= nxt.id;
          in_ch.valid     <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response monitor
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Each response item is compared against the oldest prediction. After an item
  // the monitor may hold ready low for a random number of cycles.
  always @(posedge clk) begin : resp_monitor
    cache_resp_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_responses.size() == 0) begin
          $display("%0t: unexpected response item, expected none, %s %0d slot %0d id %0h",
                   $time, "actual action", out_ch.action, out_ch.slot, out_ch.target_id);
          mismatch_count++;
        end else begin
          want = awaited_responses.pop_front();
          check_field("action",         want.action,         out_ch.action);
          check_field("slot",           want.slot,           out_ch.slot);
          check_field("target_id",      want.target_id,      out_ch.target_id);
          check_field("found",          want.found,          out_ch.found);
          check_field("hit_total",      want.hit_total,      out_ch.hit_total);
          check_field("miss_total",     want.miss_total,     out_ch.miss_total);
          check_field("eviction_total", want.eviction_total, out_ch.eviction_total);
          check_field("occupancy",      want.occupancy,      out_ch.occupancy);
          check_field("last",           want.last,           out_ch.last);
        end
        if ($urandom_range(0, 24) == 0) receiver_calm = !receiver_calm;
        recv_wait = receiver_calm ? 0 : $urandom_range(0, 11);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      out_ch.ready <= (recv_wait == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_op(logic [2:0] op, logic [ID_WIDTH-1:0] id, bit drain);
    cache_op_t c;
    c.op          = op;
    c.id          = id;
    c.drain_first = drain;
    op_queue.push_back(c);
  endtask

  // Mostly gets on a small working set so that hits, dirty lines and evictions
  // are common, with some ids from the whole range as noise.
  task automatic queue_random_ops(int count);
    logic [ID_WIDTH-1:0] id_pool [20];
    logic [ID_WIDTH-1:0] id;
    int r;
    for (int i = 0; i < 20; i++) id_pool[i] = ID_WIDTH'($urandom_range(0, 65535));
    for (int n = 0; n < count; n++) begin
      r  = $urandom_range(0, 99);
      id = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, 19)]
                                        : ID_WIDTH'($urandom_range(0, 65535));
      if (r < 52)      queue_op(lruwb_pkg::OP_GET, id, 1'b0);
      else if (r < 66) queue_op(lruwb_pkg::OP_MARK, id, 1'b0);
      else if (r < 75) queue_op(lruwb_pkg::OP_FLUSH, id, 1'b0);
      else if (r < 82) queue_op(lruwb_pkg::OP_INV, id, 1'b0);
      else if (r < 86) queue_op(lruwb_pkg::OP_FLUSH_ALL, id, 1'b0);
      else if (r < 88) queue_op(lruwb_pkg::OP_CLEAR, id, 1'b0);
      else if (r < 90) queue_op($urandom_range(0, 1) ? OP_UNDEF_HI : OP_UNDEF_LO, id, 1'b0);
      else             queue_op(lruwb_pkg::OP_GET, ID_WIDTH'($urandom_range(0, 65535)), 1'b0);
    end
  endtask

  // Fills the cache in slot order, keeps hitting slot 0 so that it stays the
  // youngest, then misses twice. Slot 1 is then the oldest and goes first with
  // a writeback, since it was made dirty beforehand, then the clean slot 2.
  task automatic queue_eviction_run();
    logic [ID_WIDTH-1:0] hot_ids [ENTRIES];
    for (int i = 0; i < ENTRIES; i++) begin
      hot_ids[i] = {12'($urandom_range(0, 4095)), 4'(i)};
    end
    queue_op(lruwb_pkg::OP_CLEAR, '0, 1'b1);
    for (int i = 0; i < ENTRIES; i++) queue_op(lruwb_pkg::OP_GET, hot_ids[i], 1'b0);
    queue_op(lruwb_pkg::OP_MARK, hot_ids[1], 1'b0);
    queue_op(lruwb_pkg::OP_MARK, hot_ids[3], 1'b0);
    for (int i = 0; i < 8; i++) queue_op(lruwb_pkg::OP_GET, hot_ids[0], 1'b0);
    queue_op(lruwb_pkg::OP_GET, ID_WIDTH'($urandom_range(0, 65535)), 1'b0);
    queue_op(lruwb_pkg::OP_GET, ID_WIDTH'($urandom_range(0, 65535)), 1'b0);
    queue_op(lruwb_pkg::OP_GET, hot_ids[0], 1'b0);
    queue_op(lruwb_pkg::OP_FLUSH_ALL, '0, 1'b0);
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      line_tag[i]   = ID_ALL_ONES;
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_age[i]   = 0;
    end
    hit_count   = '0;
    miss_count  = '0;
    evict_count = '0;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = lruwb_pkg::OP_GET;
    in_ch.item_id   = '0;
    out_ch.ready    = 1'b0;

    // Directed opening: the extreme ids (all ones is also the empty-tag value),
    // every operation on present and absent ids, clean and dirty lines, and
    // both undefined operation codes.
    queue_op(lruwb_pkg::OP_GET,       16'h0000, 1'b0);
    queue_op(lruwb_pkg::OP_GET,       16'hFFFF, 1'b0);
    queue_op(lruwb_pkg::OP_GET,       16'h0000, 1'b0);
    queue_op(lruwb_pkg::OP_MARK,      16'hFFFF, 1'b0);
    queue_op(lruwb_pkg::OP_MARK,      16'h1234, 1'b0);
    queue_op(lruwb_pkg::OP_FLUSH,     16'hFFFF, 1'b0);
    queue_op(lruwb_pkg::OP_FLUSH,     16'hFFFF, 1'b0);
    queue_op(lruwb_pkg::OP_FLUSH,     16'h4321, 1'b0);
    queue_op(lruwb_pkg::OP_MARK,      16'h0000, 1'b0);
    queue_op(lruwb_pkg::OP_INV,       16'h0000, 1'b0);
    queue_op(lruwb_pkg::OP_INV,       16'h0000, 1'b0);
    queue_op(lruwb_pkg::OP_GET,       16'hA5A5, 1'b0);
    queue_op(lruwb_pkg::OP_MARK,      16'hFFFF, 1'b0);
    queue_op(lruwb_pkg::OP_FLUSH_ALL, 16'hFFFF, 1'b0);
    queue_op(lruwb_pkg::OP_MARK,      16'hA5A5, 1'b0);
    queue_op(lruwb_pkg::OP_MARK,      16'hFFFF, 1'b0);
    queue_op(lruwb_pkg::OP_CLEAR,     16'h5A5A, 1'b0);
    queue_op(OP_UNDEF_LO,             16'h5A5A, 1'b0);
    queue_op(OP_UNDEF_HI,             16'hFFFF, 1'b0);
    queue_op(lruwb_pkg::OP_GET,       16'h8001, 1'b0);
    queue_op(lruwb_pkg::OP_INV,       16'h8001, 1'b0);
    queue_op(lruwb_pkg::OP_FLUSH_ALL, 16'h0000, 1'b0);

    queue_random_ops(40);
    queue_eviction_run();
    // Let the pipeline run dry once more before the last random stretch.
    queue_op(lruwb_pkg::OP_MARK, 16'h0000, 1'b1);
    queue_random_ops(36);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (op_queue.size() != 0 || in_ch.valid) @(posedge clk);
    while (awaited_responses.size() != 0) @(posedge clk);
    // Any stray response would show up within one scan of the entries.
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run, with every item stalled.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
